[hdl/sgs_pkg.sv]
`default_nettype none

package sgs_pkg;

    localparam int unsigned ADDR_W   = 48;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned LEN_W    = 13;
    localparam int unsigned SEGS_W   = 6;
    localparam int unsigned STATUS_W = 2;

    localparam int unsigned IN_TDATA_W  = ((ADDR_W + COUNT_W + 7) / 8) * 8;
    localparam int unsigned OUT_FIELD_W = ADDR_W + LEN_W + SEGS_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int unsigned DEF_PAGE_BYTES    = 4096;
    localparam int unsigned DEF_ADDRESS_WIDTH = 48;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 13;

    localparam logic [LEN_W-1:0]  MAX_SEG_LEN_RESET = 13'd4096;
    localparam logic [SEGS_W-1:0] SEG_CAP_RESET     = 6'd16;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_SEG_LEN  = 2'd0,
        CFG_SEG_CAPACITY = 2'd1
    } t_cfg_index;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_CAPACITY = 2'd2
    } t_status;

    typedef enum logic {
        BS_IDLE,
        BS_RUN
    } t_back_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic               invalid;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic              last;
        t_status           status;
        logic [SEGS_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

[hdl/scatter_gather_segmenter_core.sv]
// a request waits in the queue; its first result is then registered in the back end
// throughput: one result per cycle unless stalled; an invalid request gives one result,
//   a capacity error adds one more; a two-entry queue takes requests meanwhile
// reset: synchronous active low; empties the queue, drops any pending result and
//   restores max_segment_length to 4096 and segment_capacity to 16
`default_nettype none

module scatter_gather_segmenter_core
    import sgs_pkg::*;
#(
    parameter int unsigned PAGE_BYTES    = DEF_PAGE_BYTES,
    parameter int unsigned ADDRESS_WIDTH = DEF_ADDRESS_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // start_address [47:0], byte_count [79:48]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // segment_address [47:0], segment_length [60:48], segment_count [66:61], zero fill
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast,
    // status [1:0]
    output logic [STATUS_W-1:0]         m_axis_tuser,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [LEN_W-1:0]  r_max_len;
    logic [SEGS_W-1:0] r_capacity;
    t_req              w_req;
    t_req              w_head;
    logic              w_head_valid;
    logic              w_pop;
    t_result           w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= MAX_SEG_LEN_RESET;
            r_capacity <= SEG_CAP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_SEG_LEN:  r_max_len  <= i_cfg_data[LEN_W-1:0];
                CFG_SEG_CAPACITY: r_capacity <= i_cfg_data[SEGS_W-1:0];
                default: ;
            endcase
        end
    end

    sgs_front #(
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_front (
        .i_start_address(s_axis_tdata[ADDR_W-1:0]),
        .i_byte_count   (s_axis_tdata[ADDR_W+COUNT_W-1:ADDR_W]),
        .i_max_len      (r_max_len),
        .o_req          (w_req)
    );

    sgs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (s_axis_tvalid),
        .i_data (w_req),
        .o_ready(s_axis_tready),
        .o_valid(w_head_valid),
        .o_data (w_head),
        .i_pop  (w_pop)
    );

    sgs_back #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_head_valid),
        .i_q_data  (w_head),
        .o_q_pop   (w_pop),
        .i_max_len (r_max_len),
        .i_capacity(r_capacity),
        .o_valid   (m_axis_tvalid),
        .o_result  (w_result),
        .i_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                           w_result.count, w_result.len, w_result.addr};
    assign m_axis_tlast = w_result.last;
    assign m_axis_tuser = w_result.status;

`ifndef SYNTHESIS
    // every error result closes the run and carries no bytes
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |->
        (m_axis_tlast && (w_result.len == '0)))
        else $error("error result without last or with nonzero length");

    // a good segment always has bytes and is counted
    a_ok_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_OK)) |->
        ((w_result.len != '0) && (w_result.count != '0)))
        else $error("ok segment with zero length or zero count");

    // a good segment never goes past the configured maximum
    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_OK)) |->
        (w_result.len <= r_max_len))
        else $error("segment longer than maximum");

    // queue only drains through the back end when a result slot is free
    a_pop_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && m_axis_tvalid) |-> m_axis_tready)
        else $error("request taken while result stalled");
`endif

endmodule

`default_nettype wire

[hdl/sgs_front.sv]
`default_nettype none

module sgs_front
    import sgs_pkg::*;
#(
    parameter int unsigned ADDRESS_WIDTH = DEF_ADDRESS_WIDTH
) (
    input  wire logic [ADDR_W-1:0]  i_start_address,
    input  wire logic [COUNT_W-1:0] i_byte_count,
    input  wire logic [LEN_W-1:0]   i_max_len,
    output t_req                    o_req
);

    // wide enough for any address width up to 64 plus the carry
    localparam int unsigned SUM_W = 65;

    logic [SUM_W-1:0] w_end;
    logic [SUM_W-1:0] w_limit;

    always_comb begin
        w_end   = SUM_W'(i_start_address) + SUM_W'(i_byte_count);
        w_limit = (SUM_W'(1) << ADDRESS_WIDTH) - SUM_W'(1);
        o_req.addr    = i_start_address;
        o_req.count   = i_byte_count;
        // a range ending exactly at the top of the address space is rejected too
        o_req.invalid = (i_start_address == '0) || (i_byte_count == '0) ||
                        (i_max_len == '0) || (w_end > w_limit);
    end

endmodule

`default_nettype wire

[hdl/sgs_queue.sv]
`default_nettype none

module sgs_queue
    import sgs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_req      i_data,
    output logic      o_ready,
    output logic      o_valid,
    output t_req      o_data,
    input  wire logic i_pop
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_req             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + PTR_W'(1);
    endfunction

    always_comb begin
        o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
        o_valid = (r_count != '0);
        o_data  = r_mem[r_rd_ptr];
        w_push  = i_push && o_ready;
        w_pop   = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[hdl/sgs_back.sv]
`default_nettype none

module sgs_back
    import sgs_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  t_req                   i_q_data,
    output logic                   o_q_pop,
    input  wire logic [LEN_W-1:0]  i_max_len,
    input  wire logic [SEGS_W-1:0] i_capacity,
    output logic                   o_valid,
    output t_result                o_result,
    input  wire logic              i_ready
);

    // page size is a power of two
    localparam int unsigned PW = $clog2(PAGE_BYTES);
    localparam int unsigned LW = PW + 1;
    localparam int unsigned CW = (LW > LEN_W) ? LW : LEN_W;

    t_back_state        r_state;
    t_back_state        n_state;
    logic [ADDR_W-1:0]  r_cursor;
    logic [ADDR_W-1:0]  n_cursor;
    logic [COUNT_W-1:0] r_remain;
    logic [COUNT_W-1:0] n_remain;
    logic [SEGS_W-1:0]  r_used;
    logic [SEGS_W-1:0]  n_used;
    logic               r_out_valid;
    t_result            r_result;
    t_result            n_result;

    logic [ADDR_W-1:0]  w_addr;
    logic [COUNT_W-1:0] w_remain;
    logic [SEGS_W-1:0]  w_used;
    logic [LW-1:0]      w_to_boundary;
    logic [LW-1:0]      w_by_page;
    logic [LEN_W-1:0]   w_seg_len;
    logic               w_seg_last;
    logic               w_cap_hit;
    logic               w_out_free;
    logic               w_fire;

    // first segment comes straight from the queue head, later ones from the cursor
    always_comb begin
        if (r_state == BS_IDLE) begin
            w_addr   = i_q_data.addr;
            w_remain = i_q_data.count;
            w_used   = '0;
        end else begin
            w_addr   = r_cursor;
            w_remain = r_remain;
            w_used   = r_used;
        end
        w_to_boundary = LW'(PAGE_BYTES) - LW'(w_addr[PW-1:0]);
        w_by_page     = (w_remain < COUNT_W'(w_to_boundary)) ? LW'(w_remain) : w_to_boundary;
        w_seg_len     = (CW'(w_by_page) > CW'(i_max_len)) ? i_max_len : LEN_W'(w_by_page);
        w_seg_last    = (COUNT_W'(w_seg_len) == w_remain);
        w_cap_hit     = (w_used >= i_capacity);
        w_out_free    = !r_out_valid || i_ready;
        w_fire        = w_out_free && ((r_state == BS_RUN) || i_q_valid);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (w_fire && !i_q_data.invalid && !w_cap_hit && !w_seg_last) begin
                    n_state = BS_RUN;
                end
            end
            BS_RUN: begin
                if (w_fire && (w_cap_hit || w_seg_last)) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        n_cursor = w_addr + ADDR_W'(w_seg_len);
        n_remain = w_remain - COUNT_W'(w_seg_len);
        n_used   = w_used + SEGS_W'(1);
        n_result = '{addr: w_addr, len: w_seg_len, last: w_seg_last,
                     status: ST_OK, count: n_used};
        unique case (r_state)
            BS_IDLE: begin
                o_q_pop = w_fire;
                if (i_q_data.invalid) begin
                    n_result = '{addr: '0, len: '0, last: 1'b1,
                                 status: ST_INVALID, count: '0};
                end else if (w_cap_hit) begin
                    n_result = '{addr: w_addr, len: '0, last: 1'b1,
                                 status: ST_CAPACITY, count: w_used};
                end
            end
            BS_RUN: begin
                if (w_cap_hit) begin
                    n_result = '{addr: w_addr, len: '0, last: 1'b1,
                                 status: ST_CAPACITY, count: w_used};
                end
            end
            default: o_q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= n_result;
            r_cursor <= n_cursor;
            r_remain <= n_remain;
            r_used   <= n_used;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[dv/sgs_segment_checker.sv]
module sgs_segment_checker
    import sgs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   m_axis_tlast,
    input  wire logic [STATUS_W-1:0]    m_axis_tuser,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [LEN_W-1:0]  max_seg_len  = MAX_SEG_LEN_RESET;
    logic [SEGS_W-1:0] seg_capacity = SEG_CAP_RESET;
    t_result           expected_segments[$];
    int                mismatches = 0;
    int                pending    = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending;

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void push_segment(input logic [63:0] addr, input logic [63:0] len,
                                         input logic last, input t_status status,
                                         input logic [SEGS_W-1:0] count);
        t_result res;
        res.addr   = addr[ADDR_W-1:0];
        res.len    = len[LEN_W-1:0];
        res.last   = last;
        res.status = status;
        res.count  = count;
        expected_segments.push_back(res);
    endfunction

    // walks the request page by page, same order as the hardware emits
    function automatic void split_request(input logic [ADDR_W-1:0] start,
                                          input logic [COUNT_W-1:0] size);
        logic [63:0]       addr_top;
        logic [63:0]       cursor;
        logic [63:0]       remaining;
        logic [63:0]       to_boundary;
        logic [63:0]       seg_len;
        logic [SEGS_W-1:0] used;
        logic              stop;
        addr_top = (64'd1 << DEF_ADDRESS_WIDTH) - 64'd1;
        if (start == '0 || size == '0 || max_seg_len == '0 ||
            ({16'd0, start} + {32'd0, size}) > addr_top) begin
            push_segment(64'd0, 64'd0, 1'b1, ST_INVALID, '0);
        end else begin
            cursor    = {16'd0, start};
            remaining = {32'd0, size};
            used      = '0;
            stop      = 1'b0;
            while (remaining != 64'd0 && !stop) begin
                to_boundary = 64'(DEF_PAGE_BYTES) - (cursor % 64'(DEF_PAGE_BYTES));
                seg_len     = (remaining < to_boundary) ? remaining : to_boundary;
                if (seg_len > {51'd0, max_seg_len}) begin
                    seg_len = {51'd0, max_seg_len};
                end
                if (used >= seg_capacity) begin
                    push_segment(cursor, 64'd0, 1'b1, ST_CAPACITY, used);
                    stop = 1'b1;
                end else begin
                    used = used + 1'b1;
                    push_segment(cursor, seg_len, seg_len == remaining, ST_OK, used);
                    cursor    = cursor + seg_len;
                    remaining = remaining - seg_len;
                end
            end
        end
    endfunction

    task automatic check_result();
        t_result           want;
        logic [ADDR_W-1:0] got_addr;
        logic [LEN_W-1:0]  got_len;
        logic [SEGS_W-1:0] got_count;
        got_addr  = m_axis_tdata[ADDR_W-1:0];
        got_len   = m_axis_tdata[ADDR_W +: LEN_W];
        got_count = m_axis_tdata[ADDR_W+LEN_W +: SEGS_W];
        if (expected_segments.size() == 0) begin
            report_mismatch($sformatf("unexpected result addr %0h len %0d status %0d",
                                      got_addr, got_len, m_axis_tuser));
        end else begin
            want = expected_segments.pop_front();
            if (got_addr !== want.addr) begin
                report_mismatch($sformatf("segment_address %0h, want %0h", got_addr, want.addr));
            end
            if (got_len !== want.len) begin
                report_mismatch($sformatf("segment_length %0d, want %0d at %0h",
                                          got_len, want.len, want.addr));
            end
            if (m_axis_tlast !== want.last) begin
                report_mismatch($sformatf("last_of_run %0b, want %0b at %0h",
                                          m_axis_tlast, want.last, want.addr));
            end
            if (m_axis_tuser !== want.status) begin
                report_mismatch($sformatf("status %0d, want %0d at %0h",
                                          m_axis_tuser, want.status, want.addr));
            end
            if (got_count !== want.count) begin
                report_mismatch($sformatf("segment_count %0d, want %0d at %0h",
                                          got_count, want.count, want.addr));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_seg_len  = MAX_SEG_LEN_RESET;
            seg_capacity = SEG_CAP_RESET;
            expected_segments.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_SEG_LEN:  max_seg_len = i_cfg_data[LEN_W-1:0];
                    CFG_SEG_CAPACITY: seg_capacity = i_cfg_data[SEGS_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                split_request(s_axis_tdata[ADDR_W-1:0], s_axis_tdata[ADDR_W +: COUNT_W]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
            end
        end
        pending = expected_segments.size();
    end

endmodule

[dv/tb_scatter_gather_segmenter_core.sv]
module tb_scatter_gather_segmenter_core;
    import sgs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 8;
    localparam int PHASE_ITEMS      = 55;
    localparam int CAP_PAD_W        = CFG_DATA_W - SEGS_W;

    localparam logic [ADDR_W-1:0]  ADDR_TOP  = '1;
    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = CFG_MAX_SEG_LEN;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    int fail_count;
    int pending_results;
    int hold_requests = 0;
    int quiet_cycles  = 0;
    bit sender_tight  = 1'b0;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    scatter_gather_segmenter_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sgs_segment_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result sink: bursts of readiness, short and long stalls, and long holds on request
    initial begin : result_sink
        int low_left;
        int high_left;
        int holds_done;
        int pick;
        low_left   = 0;
        high_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                low_left   = LONG_HOLD_CYCLES;
                high_left  = 0;
            end else if (low_left == 0 && high_left == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    high_left = $urandom_range(1, 12);
                end else if (pick < 60) begin
                    high_left = $urandom_range(100, 300);
                end else if (pick < 92) begin
                    low_left = $urandom_range(1, 3);
                end else begin
                    low_left = $urandom_range(8, 50);
                end
            end
            if (low_left > 0) begin
                m_axis_tready <= 1'b0;
                low_left--;
            end else begin
                m_axis_tready <= 1'b1;
                high_left--;
            end
        end
    end

    function automatic int request_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (sender_tight || pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called on a clock edge; returns on the edge where the transaction completes
    task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [COUNT_W-1:0] bytes);
        int gap;
        gap = request_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bytes, addr};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only while idle: both registers back to back, valid held across them
    task automatic write_settings(input logic [CFG_DATA_W-1:0] max_len,
                                  input logic [CFG_DATA_W-1:0] capacity);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MAX_SEG_LEN;
        i_cfg_data  <= max_len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_SEG_CAPACITY;
        i_cfg_data  <= capacity;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_request(output logic [ADDR_W-1:0] addr,
                                  output logic [COUNT_W-1:0] bytes);
        int          pick;
        logic [63:0] bits;
        pick  = $urandom_range(0, 99);
        bits  = {$urandom, $urandom};
        addr  = bits[ADDR_W-1:0];
        bytes = $urandom_range(1, 12288);
        if (pick < 40) begin
            // plain request over a couple of pages
        end else if (pick < 55) begin
            // start on or just before a page boundary
            addr[11:0] = (pick < 48) ? 12'h000 : 12'hFFF - 12'($urandom_range(0, 16));
            bytes      = $urandom_range(1, 9000);
        end else if (pick < 65) begin
            bytes = $urandom;
        end else if (pick < 72) begin
            addr  = ADDR_W'($urandom_range(1, 8191));
            bytes = $urandom_range(1, 300);
        end else if (pick < 80) begin
            // near the top of the address space, some of these wrap
            addr  = ADDR_TOP - ADDR_W'($urandom_range(0, 20000));
            bytes = $urandom_range(1, 20000);
        end else if (pick < 84) begin
            addr = '0;
        end else if (pick < 88) begin
            bytes = '0;
        end else begin
            bytes = $urandom_range(1, 64);
        end
    endtask

    initial begin : stimulus
        logic [ADDR_W-1:0]     addr;
        logic [COUNT_W-1:0]    bytes;
        logic [CFG_DATA_W-1:0] max_len;
        logic [CFG_DATA_W-1:0] capacity;
        int                    items;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 4096 max, 16 segments
        send_request(48'h1, 32'h1);
        send_request(48'h1000, 32'd4096);
        send_request(48'hFFF, 32'd2);
        send_request(48'h800, 32'd8192);
        send_request(48'h0, 32'd100);
        send_request(48'h1234, 32'h0);
        send_request(ADDR_TOP, 32'd1);
        send_request(ADDR_TOP - 48'd1, 32'd1);
        send_request(ADDR_TOP, COUNT_TOP);
        send_request(48'h1000, 32'd65536);
        send_request(48'h1000, 32'd65537);
        send_request(48'h123, COUNT_TOP);
        send_request(48'h7FFF_FFFF_F001, 32'd5000);
        wait_all_results();

        write_settings(13'd100, 13'd3);
        send_request(48'hFF0, 32'd300);
        send_request(48'h2000, 32'd250);
        wait_all_results();

        // zero maximum rejects everything
        write_settings(13'd0, 13'd16);
        send_request(48'h1000, 32'd10);
        wait_all_results();

        // zero capacity with a maximum above the page size
        write_settings(13'h1FFF, 13'd0);
        send_request(48'h1000, 32'd5);
        send_request(48'h800, 32'd9000);
        wait_all_results();

        write_settings(13'h1FFF, 13'h1FFF);
        send_request(48'h800, 32'd20000);
        wait_all_results();

        for (int phase = 0; phase < 9; phase++) begin
            items = PHASE_ITEMS;
            case (phase)
                0: begin max_len = 13'd4096; capacity = 13'd16; end
                1: begin max_len = 13'd4096; capacity = 13'd63; end
                2: begin max_len = 13'd1;    capacity = 13'd63; end
                3: begin max_len = 13'd8191; capacity = 13'd40; end
                4: begin max_len = 13'd0;    capacity = 13'd16; items = 10; end
                5: begin
                    max_len  = CFG_DATA_W'($urandom_range(1, 4096));
                    capacity = CFG_DATA_W'($urandom_range(0, 63));
                end
                6: begin max_len = 13'd4095; capacity = 13'd1; end
                7: begin
                    max_len  = 13'd4097;
                    capacity = CFG_DATA_W'($urandom_range(0, 63));
                end
                default: begin
                    max_len  = CFG_DATA_W'($urandom_range(1, 8191));
                    capacity = CFG_DATA_W'($urandom_range(0, 63));
                end
            endcase
            // upper data bits are don't-care for the capacity register
            capacity[CFG_DATA_W-1:SEGS_W] = CAP_PAD_W'($urandom_range(0, 127));
            write_settings(max_len, capacity);
            sender_tight = (phase == 1 || phase == 2);
            if (phase == 1) begin
                hold_requests++;
            end
            repeat (items) begin
                random_request(addr, bytes);
                send_request(addr, bytes);
            end
            wait_all_results();
        end

        if (fail_count == 0 && pending_results == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/sgs_pkg.sv
hdl/sgs_front.sv
hdl/sgs_queue.sv
hdl/sgs_back.sv
hdl/scatter_gather_segmenter_core.sv
dv/sgs_segment_checker.sv
dv/tb_scatter_gather_segmenter_core.sv
